// File: src/dmd_pkg.sv
package dmd_pkg;

  // number of consoles on the line, fixed by the two-bit port field
  localparam int unsigned CONSOLE_COUNT = 4;
  localparam int unsigned PORT_W        = $clog2(CONSOLE_COUNT);

  // bus access codes
  typedef enum logic [1:0] {
    CMD_CTRL_WR = 2'd0,
    CMD_STAT_RD = 2'd1,
    CMD_DATA_WR = 2'd2,
    CMD_LINE_OK = 2'd3
  } cmd_t;

  // frame parser phases
  typedef enum logic [2:0] {
    PH_SOH  = 3'd0,
    PH_ADR  = 3'd1,
    PH_STAT = 3'd2,
    PH_STX  = 3'd3,
    PH_TEXT = 3'd4,
    PH_LP   = 3'd5
  } phase_t;

  // frame control characters
  localparam logic [6:0] CH_SOH  = 7'h01;
  localparam logic [6:0] CH_STX  = 7'h02;
  localparam logic [6:0] CH_ETX  = 7'h03;
  localparam logic [6:0] CH_MASK = 7'h7f;

  // address characters select consoles 0..3: 1 1 c c 0 0 0
  localparam logic [1:0] ADR_HIGH = 2'b11;

  // bit positions in bus words
  localparam int unsigned FORCE_DONE_BIT = 7;
  localparam int unsigned DONE_RD_BIT    = 6;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] bus_data;
  } access_t;

  typedef struct packed {
    logic [6:0]        read_data;
    logic              irq_request;
    logic [2:0]        irq_channel;
    logic              send_valid;
    logic [6:0]        send_char;
    logic [PORT_W-1:0] send_port;
    logic              parity_error;
  } result_t;

endpackage

// File: src/dmd_access_if.sv
interface dmd_access_if;
  logic             valid;
  logic             ready;
  dmd_pkg::access_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: src/dmd_result_if.sv
interface dmd_result_if;
  logic             valid;
  logic             ready;
  dmd_pkg::result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: src/dmd_core.sv
module dmd_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step_en,
  input  dmd_pkg::access_t acc,
  output dmd_pkg::result_t res
);
  import dmd_pkg::*;

  phase_t            phase, phase_next;
  logic [PORT_W-1:0] console_select, console_select_next;
  logic [6:0]        running_parity, running_parity_next;
  logic [2:0]        channel_assign, channel_assign_next;
  logic              done_flag, done_flag_next;
  logic              irq_pending, irq_pending_next;
  logic              send_outstanding, send_outstanding_next;

  logic [6:0] inv_char;
  logic [6:0] ch;
  logic [6:0] parity_x;
  logic       adr_ok;

  // decode: invert, then rotate left by one within 7 bits
  assign inv_char = acc.bus_data[6:0] ^ CH_MASK;
  assign ch       = {inv_char[5:0], inv_char[6]};
  assign parity_x = running_parity ^ ch;
  assign adr_ok   = (ch[6:5] == ADR_HIGH) && (ch[2:0] == 3'd0);

  // next state
  always_comb begin
    phase_next            = phase;
    console_select_next   = console_select;
    running_parity_next   = running_parity;
    channel_assign_next   = channel_assign;
    done_flag_next        = done_flag;
    irq_pending_next      = irq_pending;
    send_outstanding_next = send_outstanding;
    case (acc.command)
      CMD_CTRL_WR: begin
        irq_pending_next    = 1'b0;
        channel_assign_next = acc.bus_data[2:0];
        if (acc.bus_data[FORCE_DONE_BIT]) begin
          done_flag_next   = 1'b1;
          irq_pending_next = 1'b1;
        end
      end
      CMD_STAT_RD: begin
      end
      CMD_DATA_WR: begin
        if (done_flag) begin
          running_parity_next = parity_x;
          // every frame character except text sets done again at once
          done_flag_next      = 1'b1;
          irq_pending_next    = 1'b1;
          case (phase)
            PH_ADR: begin
              if (adr_ok) begin
                console_select_next = ch[4:3];
                phase_next          = PH_STAT;
              end else begin
                phase_next = PH_SOH;
              end
            end
            PH_STAT: begin
              phase_next = (ch == 7'd0) ? PH_STX : PH_SOH;
            end
            PH_STX: begin
              if (ch == CH_STX) begin
                phase_next = PH_TEXT;
              end
            end
            PH_TEXT: begin
              if (ch == CH_ETX) begin
                phase_next = PH_LP;
              end else begin
                done_flag_next        = 1'b0;
                irq_pending_next      = 1'b0;
                send_outstanding_next = 1'b1;
              end
            end
            PH_LP: begin
              phase_next = PH_SOH;
            end
            default: begin
              // parity restarts after the start of header
              if (ch == CH_SOH) begin
                phase_next          = PH_ADR;
                running_parity_next = 7'd0;
              end else begin
                phase_next = PH_SOH;
              end
            end
          endcase
        end
      end
      default: begin
        if (send_outstanding) begin
          send_outstanding_next = 1'b0;
          done_flag_next        = 1'b1;
          irq_pending_next      = 1'b1;
        end
      end
    endcase
  end

  // result of this access
  always_comb begin
    res              = '0;
    res.irq_request  = irq_pending_next && (channel_assign_next != 3'd0);
    res.irq_channel  = channel_assign_next;
    if (acc.command == CMD_STAT_RD) begin
      res.read_data = {done_flag, 3'd0, channel_assign};
    end
    if ((acc.command == CMD_DATA_WR) && done_flag) begin
      if ((phase == PH_TEXT) && (ch != CH_ETX)) begin
        res.send_valid = 1'b1;
        res.send_char  = ch;
        res.send_port  = console_select;
      end
      if (phase == PH_LP) begin
        res.parity_error = (parity_x != 7'd0);
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_SOH;
      console_select   <= '0;
      running_parity   <= '0;
      channel_assign   <= '0;
      done_flag        <= 1'b0;
      irq_pending      <= 1'b0;
      send_outstanding <= 1'b0;
    end else if (step_en) begin
      phase            <= phase_next;
      console_select   <= console_select_next;
      running_parity   <= running_parity_next;
      channel_assign   <= channel_assign_next;
      done_flag        <= done_flag_next;
      irq_pending      <= irq_pending_next;
      send_outstanding <= send_outstanding_next;
    end
  end

  // an issued text character leaves done clear and a send outstanding
  a_send_waits: assert property (@(posedge clk) disable iff (rst)
    step_en && res.send_valid |=> !done_flag && send_outstanding)
    else $error("text character issued without waiting for the line");

  // the parity byte returns the parser to start of header, checked when it flags an error
  a_lp_ends: assert property (@(posedge clk) disable iff (rst)
    step_en && res.parity_error |=> phase == PH_SOH)
    else $error("parity byte did not end the frame");

  // no state moves without an access
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !step_en |=> $stable(phase) && $stable(running_parity) && $stable(done_flag))
    else $error("parser state changed without an access");

  // reset leaves the parser idle with done clear
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> phase == PH_SOH && !done_flag && !send_outstanding)
    else $error("state not cleared by reset");

endmodule

// File: src/display_message_deframer.sv
// Display message deframer: output side of a four-console display interface.
// Channel "access" carries one bus access (command, bus_data); channel
// "result" returns exactly one result item per access, in order.
// Both channels use valid/ready; a request moves when both are high.
// Pipeline: an input register holds the access, the parser logic runs
// between it and the result register, so a result is registered when its
// access advances, which waits while the result register is full and stalled.
// One access is taken every cycle while results are drained, since the
// input register refills in the same cycle it advances.
// Parser state (frame phase, console, parity, channel, done, interrupt)
// updates when an access moves from the input register to the result
// register, so accesses take effect strictly in order.
// When the receiver stalls, the result register holds its item, the input
// register holds one more access, and then access.ready drops.
// Synchronous reset empties both registers, the parser returns to waiting
// for start of header, and done, interrupt and channel are cleared.
module display_message_deframer (
  input  logic          clk,
  input  logic          rst,
  dmd_access_if.sink    access,
  dmd_result_if.source  result
);
  import dmd_pkg::*;

  logic    in_valid;
  access_t in_acc;
  logic    res_valid;
  result_t res_data;
  result_t core_res;
  logic    advance;

  // move the held access into the result register when it has room
  assign advance      = in_valid && (!res_valid || result.ready);
  assign access.ready = !in_valid || advance;

  dmd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step_en (advance),
    .acc     (in_acc),
    .res     (core_res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (access.ready) begin
      in_valid <= access.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (access.valid && access.ready) begin
      in_acc <= access.payload;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_data <= core_res;
    end
  end

  assign result.valid   = res_valid;
  assign result.payload = res_data;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import dmd_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1050;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_PRINTS   = 40;

  // one row of the directed plan; for data writes the value is the decoded character
  typedef struct {
    cmd_t       cmd;
    logic [7:0] value;
    bit         typed;
    result_t    want;
  } plan_row_t;

  localparam int unsigned PLAN_LEN = 28;

  logic clk;
  logic rst = 1'b1;

  dmd_access_if acc ();
  dmd_result_if res ();

  display_message_deframer dut (
    .clk    (clk),
    .rst    (rst),
    .access (acc),
    .result (res)
  );

  // predictor state
  phase_t            m_phase;
  logic [PORT_W-1:0] m_console;
  logic [6:0]        m_parity;
  logic [2:0]        m_chan;
  logic              m_done;
  logic              m_irq;
  logic              m_sent;

  result_t     expected_results [$];
  int unsigned mismatch_count;
  int unsigned useful_sent;
  int unsigned cycle_count;
  int unsigned sender_idle_pct;
  int unsigned stall_pct;

  // directed plan: after reset, ignored requests, channel zero, one full frame,
  // then frames broken by a bad address and by a nonzero status byte
  plan_row_t plan [PLAN_LEN] = '{
    '{CMD_STAT_RD, 8'h00, 1'b1, '{7'h00, 1'b0, 3'd0, 1'b0, 7'h00, 2'd0, 1'b0}},
    '{CMD_DATA_WR, 8'h55, 1'b1, '{7'h00, 1'b0, 3'd0, 1'b0, 7'h00, 2'd0, 1'b0}},
    '{CMD_LINE_OK, 8'h00, 1'b1, '{7'h00, 1'b0, 3'd0, 1'b0, 7'h00, 2'd0, 1'b0}},
    '{CMD_CTRL_WR, 8'h87, 1'b1, '{7'h00, 1'b1, 3'd7, 1'b0, 7'h00, 2'd0, 1'b0}},
    '{CMD_STAT_RD, 8'hff, 1'b1, '{7'h47, 1'b1, 3'd7, 1'b0, 7'h00, 2'd0, 1'b0}},
    '{CMD_CTRL_WR, 8'h80, 1'b1, '{7'h00, 1'b0, 3'd0, 1'b0, 7'h00, 2'd0, 1'b0}},
    '{CMD_STAT_RD, 8'h00, 1'b1, '{7'h40, 1'b0, 3'd0, 1'b0, 7'h00, 2'd0, 1'b0}},
    '{CMD_CTRL_WR, 8'h02, 1'b1, '{7'h00, 1'b0, 3'd2, 1'b0, 7'h00, 2'd0, 1'b0}},
    '{CMD_CTRL_WR, 8'h83, 1'b1, '{7'h00, 1'b1, 3'd3, 1'b0, 7'h00, 2'd0, 1'b0}},
    '{CMD_DATA_WR, 8'h7f, 1'b0, '0},
    '{CMD_DATA_WR, 8'h01, 1'b0, '0},
    '{CMD_DATA_WR, 8'h78, 1'b0, '0},
    '{CMD_DATA_WR, 8'h00, 1'b0, '0},
    '{CMD_DATA_WR, 8'h41, 1'b0, '0},
    '{CMD_DATA_WR, 8'h02, 1'b0, '0},
    '{CMD_DATA_WR, 8'h00, 1'b0, '0},
    '{CMD_DATA_WR, 8'h11, 1'b0, '0},
    '{CMD_LINE_OK, 8'hff, 1'b0, '0},
    '{CMD_DATA_WR, 8'h7f, 1'b0, '0},
    '{CMD_LINE_OK, 8'h00, 1'b0, '0},
    '{CMD_LINE_OK, 8'h00, 1'b0, '0},
    '{CMD_DATA_WR, 8'h03, 1'b0, '0},
    '{CMD_DATA_WR, 8'h2a, 1'b0, '0},
    '{CMD_DATA_WR, 8'h01, 1'b0, '0},
    '{CMD_DATA_WR, 8'h61, 1'b0, '0},
    '{CMD_DATA_WR, 8'h01, 1'b0, '0},
    '{CMD_DATA_WR, 8'h60, 1'b0, '0},
    '{CMD_DATA_WR, 8'h05, 1'b0, '0}
  };

  // bus word whose decoded character is c: rotate right, invert, random bit 7
  function automatic logic [7:0] char_to_bus(input logic [6:0] c);
    logic [6:0] r;
    r = {c[0], c[6:1]};
    return {1'($urandom_range(1)), ~r};
  endfunction

  // deframer behavior for one request, updating the predictor state
  function automatic result_t predict_result(input access_t a);
    result_t    r;
    logic [6:0] c;
    bit         rearm;
    r = '0;
    rearm = 1'b1;
    case (a.command)
      CMD_CTRL_WR: begin
        m_irq = 1'b0;
        m_chan = a.bus_data[2:0];
        if (a.bus_data[FORCE_DONE_BIT]) begin
          m_done = 1'b1;
          m_irq = 1'b1;
        end
      end
      CMD_STAT_RD: begin
        r.read_data = 7'(m_chan) | (7'(m_done) << DONE_RD_BIT);
      end
      CMD_DATA_WR: begin
        if (m_done) begin
          m_irq = 1'b0;
          m_done = 1'b0;
          c = ~a.bus_data[6:0];
          c = {c[5:0], c[6]};
          m_parity = m_parity ^ c;
          case (m_phase)
            PH_ADR: begin
              if (c[6:5] == ADR_HIGH && c[2:0] == 3'b000) begin
                m_console = c[4:3];
                m_phase = PH_STAT;
              end else begin
                m_phase = PH_SOH;
              end
            end
            PH_STAT: begin
              if (c == 7'h00) m_phase = PH_STX;
              else m_phase = PH_SOH;
            end
            PH_STX: begin
              if (c == CH_STX) m_phase = PH_TEXT;
            end
            PH_TEXT: begin
              if (c == CH_ETX) begin
                m_phase = PH_LP;
              end else begin
                // text goes out and waits for the line
                r.send_valid = 1'b1;
                r.send_char = c;
                r.send_port = m_console;
                m_sent = 1'b1;
                rearm = 1'b0;
              end
            end
            PH_LP: begin
              r.parity_error = (m_parity != 7'h00);
              m_phase = PH_SOH;
            end
            default: begin
              // parity restarts after the start of header
              if (c == CH_SOH) begin
                m_phase = PH_ADR;
                m_parity = 7'h00;
              end else begin
                m_phase = PH_SOH;
              end
            end
          endcase
          if (rearm) begin
            m_done = 1'b1;
            m_irq = 1'b1;
          end
        end
      end
      default: begin
        if (m_sent) begin
          m_sent = 1'b0;
          m_done = 1'b1;
          m_irq = 1'b1;
        end
      end
    endcase
    r.irq_request = m_irq && (m_chan != 3'd0);
    r.irq_channel = m_chan;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got_v,
                                 input int unsigned want_v);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h",
               cycle_count, what, got_v, want_v);
  endtask

  task automatic check_field(input string what, input int unsigned got_v,
                             input int unsigned want_v);
    if (got_v != want_v) report_mismatch(what, got_v, want_v);
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result with nothing expected", 32'(got), 0);
      return;
    end
    want = expected_results.pop_front();
    check_field("read_data", 32'(got.read_data), 32'(want.read_data));
    check_field("irq_request", 32'(got.irq_request), 32'(want.irq_request));
    check_field("irq_channel", 32'(got.irq_channel), 32'(want.irq_channel));
    check_field("send_valid", 32'(got.send_valid), 32'(want.send_valid));
    check_field("send_char", 32'(got.send_char), 32'(want.send_char));
    check_field("send_port", 32'(got.send_port), 32'(want.send_port));
    check_field("parity_error", 32'(got.parity_error), 32'(want.parity_error));
  endtask

  // drive one request with a random gap, wait for acceptance, record expectation
  task automatic send_access(input access_t a, input bit typed, input result_t want);
    int unsigned gap;
    result_t     pred;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      acc.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    acc.valid <= 1'b1;
    acc.payload <= a;
    @(posedge clk);
    while (!acc.ready) @(posedge clk);
    if (!((a.command == CMD_DATA_WR && !m_done) || (a.command == CMD_LINE_OK && !m_sent)))
      useful_sent++;
    pred = predict_result(a);
    expected_results.push_back(typed ? want : pred);
  endtask

  task automatic send_cmd(input cmd_t cmd, input logic [7:0] data);
    access_t a;
    a.command = cmd;
    a.bus_data = data;
    send_access(a, 1'b0, '0);
  endtask

  task automatic send_char(input logic [6:0] c);
    send_cmd(CMD_DATA_WR, char_to_bus(c));
  endtask

  // one frame, mostly well formed, with random content and occasional breakage
  task automatic run_frame();
    int unsigned text_len;
    logic [6:0]  c;
    send_cmd(CMD_CTRL_WR, {1'b1, 7'($urandom_range(127))});
    if ($urandom_range(99) < 90) send_char(CH_SOH);
    else send_char(7'($urandom_range(127)));
    if ($urandom_range(99) < 85) send_char({ADR_HIGH, 2'($urandom_range(3)), 3'b000});
    else send_char(7'($urandom_range(127)));
    if ($urandom_range(99) < 90) send_char(7'h00);
    else send_char(7'($urandom_range(127)));
    if ($urandom_range(99) < 20)
      repeat ($urandom_range(1, 2)) send_char(7'($urandom_range(127)));
    send_char(CH_STX);
    text_len = $urandom_range(0, 6);
    repeat (text_len) begin
      c = 7'($urandom_range(127));
      while (c == CH_ETX) c = 7'($urandom_range(127));
      send_char(c);
      // stray requests while the line still holds the character
      if ($urandom_range(99) < 15) begin
        if ($urandom_range(1) == 0) send_char(7'($urandom_range(127)));
        else send_cmd(CMD_STAT_RD, 8'($urandom_range(255)));
      end
      if ($urandom_range(99) < 95) send_cmd(CMD_LINE_OK, 8'($urandom_range(255)));
    end
    send_char(CH_ETX);
    if ($urandom_range(99) < 80) send_char(m_parity);
    else send_char(7'($urandom_range(127)));
    // noise between frames
    if ($urandom_range(99) < 30)
      repeat ($urandom_range(1, 3))
        send_cmd(cmd_t'($urandom_range(3)), 8'($urandom_range(255)));
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: random stalls and checking
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(99) >= stall_pct);
      if (res.valid && res.ready) check_result(res.payload);
    end
  end

  // stimulus
  initial begin
    access_t a;
    acc.valid <= 1'b0;
    acc.payload <= '0;
    useful_sent = 0;
    sender_idle_pct = 0;
    stall_pct = 0;
    m_phase = PH_SOH;
    m_console = '0;
    m_parity = 7'h00;
    m_chan = 3'd0;
    m_done = 1'b0;
    m_irq = 1'b0;
    m_sent = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed plan
    foreach (plan[i]) begin
      a.command = plan[i].cmd;
      a.bus_data = (plan[i].cmd == CMD_DATA_WR) ? char_to_bus(plan[i].value[6:0])
                                                : plan[i].value;
      send_access(a, plan[i].typed, plan[i].want);
    end

    // random frames through the idling phases
    useful_sent = 0;
    while (useful_sent < RANDOM_ITEMS) begin
      case (useful_sent * 4 / RANDOM_ITEMS)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 51; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 51; end
        default: begin sender_idle_pct = 12; stall_pct = 12; end
      endcase
      run_frame();
    end
    acc.valid <= 1'b0;

    // drain
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
src/dmd_pkg.sv
src/dmd_access_if.sv
src/dmd_result_if.sv
src/dmd_core.sv
src/display_message_deframer.sv
verif/tb_top.sv
